[src/arpeggiator_note_engine_unit_defines.svh]
// Assertion helpers shared by the checking code of the arpeggiator engine.
// Each one expects clk and arst_n in scope.
`ifndef ARPEGGIATOR_NOTE_ENGINE_UNIT_DEFINES_SVH
`define ARPEGGIATOR_NOTE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define ARPNE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ARPNE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/arpne_pkg.sv]
package arpne_pkg;

	localparam int DEF_HELD_CAPACITY = 16;

	localparam int NOTE_W      = 7;
	localparam int CMD_W       = 3;
	localparam int STEP_W      = 4;
	localparam int RND_W       = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 8;

	localparam int MODE_W     = 2;
	localparam int SPAN_W     = 3;
	localparam int DIV_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam int MOD_NUM_W = 8;
	localparam int MOD_DEN_W = 6;

	localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
	localparam int OCTAVE_STEP = 12;

	typedef enum logic [CMD_W-1:0] {
		CMD_KEY_DOWN = 3'd0,
		CMD_KEY_UP   = 3'd1,
		CMD_STEP     = 3'd2,
		CMD_GATE_REL = 3'd3,
		CMD_CLEAR    = 3'd4,
		CMD_START    = 3'd5,
		CMD_STOP     = 3'd6
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_UP     = 2'd0,
		MODE_DOWN   = 2'd1,
		MODE_UPDOWN = 2'd2,
		MODE_RANDOM = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARP_MODE      = 2'd0,
		REG_OCTAVE_SPAN   = 2'd1,
		REG_STEP_DIVISION = 2'd2,
		REG_LATCH         = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		EV_NOTE_ON  = 1'b0,
		EV_NOTE_OFF = 1'b1
	} event_t;

	typedef struct packed {
		mode_t             mode;
		logic [SPAN_W-1:0] span;
		logic [DIV_W-1:0]  div;
		logic              latch;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		event_t            ev;
		logic [NOTE_W-1:0] note;
		logic              last;
	} out_push_t;

	typedef struct packed {
		logic                 start;
		logic [MOD_NUM_W-1:0] num;
		logic [MOD_DEN_W-1:0] den;
	} mod_req_t;

	typedef struct packed {
		logic                 done;
		logic [MOD_DEN_W-1:0] rem;
	} mod_rsp_t;

endpackage

[src/arpne_held_mem.sv]
module arpne_held_mem
	import arpne_pkg::*;
#(
	parameter int HELD_CAPACITY = DEF_HELD_CAPACITY,
	localparam int IDX_W = $clog2(HELD_CAPACITY)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [NOTE_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [NOTE_W-1:0] rdata
);

	logic [NOTE_W-1:0] mem [HELD_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/arpne_mod.sv]
module arpne_mod
	import arpne_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	localparam int CNT_W = $clog2(MOD_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_NUM_W-1:0] num_q;
	logic [MOD_DEN_W-1:0] den_q;
	logic [MOD_DEN_W-1:0] rem_q;

	logic [MOD_DEN_W:0] trial;
	logic [MOD_DEN_W:0] diff;
	logic [MOD_DEN_W-1:0] rem_next;

	// one quotient bit a cycle, restoring form
	always_comb begin
		trial    = {rem_q, num_q[MOD_NUM_W-1]};
		diff     = trial - {1'b0, den_q};
		rem_next = (trial >= {1'b0, den_q}) ? diff[MOD_DEN_W-1:0] : trial[MOD_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MOD_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[MOD_NUM_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

[src/arpne_ctrl.sv]
module arpne_ctrl
	import arpne_pkg::*;
#(
	parameter int HELD_CAPACITY = DEF_HELD_CAPACITY,
	localparam int IDX_W = $clog2(HELD_CAPACITY),
	localparam int CNT_W = $clog2(HELD_CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CMD_W-1:0]  in_cmd,
	input  logic [NOTE_W-1:0] in_note,
	input  logic [STEP_W-1:0] in_step,
	input  logic [RND_W-1:0]  in_rnd,
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output logic [NOTE_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [IDX_W-1:0]  mem_raddr,
	input  logic [NOTE_W-1:0] mem_rdata,
	output mod_req_t          mod_req,
	input  mod_rsp_t          mod_rsp,
	input  logic              slot_free,
	output out_push_t         push
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_DUP  = 11'b000_0000_0010,
		S_INS  = 11'b000_0000_0100,
		S_INS0 = 11'b000_0000_1000,
		S_DEL  = 11'b000_0001_0000,
		S_DIV  = 11'b000_0010_0000,
		S_RND  = 11'b000_0100_0000,
		S_RD   = 11'b000_1000_0000,
		S_NOTE = 11'b001_0000_0000,
		S_OFF  = 11'b010_0000_0000,
		S_ON   = 11'b100_0000_0000
	} state_t;

	function automatic logic [DIV_W-1:0] div_clamp(input logic [DIV_W-1:0] d);
		priority if (d == '0) return DIV_W'(1);
		else if (d > DIV_W'(16)) return DIV_W'(16);
		else return d;
	endfunction

	function automatic logic [5:0] span_semitones(input logic [SPAN_W-1:0] span,
			input logic [STEP_W-1:0] step);
		logic [STEP_W-1:0] r;
		logic [1:0]        slot;
		r    = step;
		slot = '0;
		priority if (span >= SPAN_W'(4)) begin
			slot = step[1:0];
		end else if (span == SPAN_W'(3)) begin
			if (r >= STEP_W'(12)) r = r - STEP_W'(12);
			if (r >= STEP_W'(6)) r = r - STEP_W'(6);
			if (r >= STEP_W'(3)) r = r - STEP_W'(3);
			slot = r[1:0];
		end else if (span == SPAN_W'(2)) begin
			slot = {1'b0, step[0]};
		end else begin
			slot = '0;
		end
		return 6'(slot) * 6'(OCTAVE_STEP);
	endfunction

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  total_q, total_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic              none_q, none_d;
	logic              down_q, down_d;
	logic [3:0]        dc_q, dc_d;
	logic [NOTE_W-1:0] snd_note_q, snd_note_d;
	logic              snd_act_q, snd_act_d;
	logic              found_q, found_d;
	logic              on_pend_q, on_pend_d;
	logic [CNT_W-1:0]  wk_q, wk_d;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [NOTE_W-1:0] note_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  rnd_q;
	logic [NOTE_W-1:0] next_note_q, next_note_d;

	logic              accept;
	cmd_t              cmd_c;
	logic [CNT_W-1:0]  tot_m1, tot_m2, pos_ext, pos_p1, pos_m1, wk_m1, ins_waddr;
	logic              is_last_s1;
	logic [CNT_W-1:0]  pick_pos;
	logic              pick_down;
	logic [NOTE_W:0]   note_sum;
	logic [NOTE_W-1:0] note_val;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign cmd_c    = cmd_t'(in_cmd);

	assign tot_m1     = total_q - CNT_W'(1);
	assign tot_m2     = total_q - CNT_W'(2);
	assign pos_ext    = CNT_W'(pos_q);
	assign pos_p1     = pos_ext + CNT_W'(1);
	assign pos_m1     = pos_ext - CNT_W'(1);
	assign wk_m1      = wk_q - CNT_W'(1);
	assign ins_waddr  = CNT_W'(rd_idx_s1) + CNT_W'(1);
	assign is_last_s1 = (CNT_W'(rd_idx_s1) == tot_m1);

	assign note_sum = {1'b0, mem_rdata} + (NOTE_W + 1)'(span_semitones(cfg.span, step_q));
	assign note_val = (note_sum > {1'b0, NOTE_MAX}) ? NOTE_MAX : note_sum[NOTE_W-1:0];

	// next play position for the selected order
	always_comb begin
		pick_pos  = '0;
		pick_down = down_q;
		unique case (cfg.mode)
			MODE_UP: begin
				pick_pos = (none_q || pos_p1 == total_q) ? '0 : pos_p1;
			end
			MODE_DOWN: begin
				pick_pos = (none_q || pos_q == '0) ? tot_m1 : pos_m1;
			end
			MODE_UPDOWN: begin
				if (none_q) begin
					pick_pos = '0;
				end else if (!down_q) begin
					if (pos_p1 >= total_q) begin
						pick_pos  = (total_q > CNT_W'(1)) ? tot_m2 : '0;
						pick_down = 1'b1;
					end else begin
						pick_pos = pos_p1;
					end
				end else begin
					if (pos_q == '0) begin
						pick_pos  = (total_q > CNT_W'(1)) ? CNT_W'(1) : '0;
						pick_down = 1'b0;
					end else begin
						pick_pos = pos_m1;
					end
				end
			end
			MODE_RANDOM: begin
				pick_pos = CNT_W'(mod_rsp.rem);
			end
			default: begin
				pick_pos = '0;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		total_d     = total_q;
		pos_d       = pos_q;
		none_d      = none_q;
		down_d      = down_q;
		dc_d        = dc_q;
		snd_note_d  = snd_note_q;
		snd_act_d   = snd_act_q;
		found_d     = found_q;
		on_pend_d   = on_pend_q;
		wk_d        = wk_q;
		next_note_d = next_note_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = '0;
		mod_req     = '0;
		push        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_c)
						CMD_KEY_DOWN: begin
							if (total_q == '0) begin
								mem_we    = 1'b1;
								mem_waddr = '0;
								mem_wdata = in_note;
								total_d   = CNT_W'(1);
							end else if (total_q != CNT_W'(HELD_CAPACITY)) begin
								wk_d    = '0;
								state_d = S_DUP;
							end
						end
						CMD_KEY_UP: begin
							if (!cfg.latch && total_q != '0) begin
								wk_d    = '0;
								found_d = 1'b0;
								state_d = S_DEL;
							end
						end
						CMD_STEP: begin
							if (total_q == '0) begin
								on_pend_d = 1'b0;
								if (snd_act_q) state_d = S_OFF;
							end else begin
								mod_req.start = 1'b1;
								mod_req.num   = MOD_NUM_W'({1'b0, dc_q} + 5'd1);
								mod_req.den   = MOD_DEN_W'(div_clamp(cfg.div));
								state_d       = S_DIV;
							end
						end
						CMD_GATE_REL, CMD_STOP: begin
							on_pend_d = 1'b0;
							if (snd_act_q) state_d = S_OFF;
						end
						CMD_CLEAR: begin
							total_d   = '0;
							none_d    = 1'b1;
							on_pend_d = 1'b0;
							if (snd_act_q) state_d = S_OFF;
						end
						CMD_START: begin
							dc_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_DUP: begin
				if (wk_q < total_q) begin
					mem_re    = 1'b1;
					mem_raddr = wk_q[IDX_W-1:0];
					wk_d      = wk_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					if (mem_rdata == note_q) begin
						state_d = S_IDLE;
					end else if (is_last_s1) begin
						wk_d    = total_q;
						state_d = S_INS;
					end
				end
			end
			S_INS: begin
				// walk down from the top, moving larger entries up by one
				if (wk_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = wk_m1[IDX_W-1:0];
					wk_d      = wk_m1;
				end
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ins_waddr[IDX_W-1:0];
					if (mem_rdata > note_q) begin
						mem_wdata = mem_rdata;
						if (rd_idx_s1 == '0) state_d = S_INS0;
					end else begin
						mem_wdata = note_q;
						total_d   = total_q + CNT_W'(1);
						state_d   = S_IDLE;
					end
				end
			end
			S_INS0: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = note_q;
				total_d   = total_q + CNT_W'(1);
				state_d   = S_IDLE;
			end
			S_DEL: begin
				if (wk_q < total_q) begin
					mem_re    = 1'b1;
					mem_raddr = wk_q[IDX_W-1:0];
					wk_d      = wk_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					// once the note is found, pull each later entry down by one
					if (found_q) begin
						mem_we    = 1'b1;
						mem_waddr = rd_idx_s1 - IDX_W'(1);
						mem_wdata = mem_rdata;
					end else if (mem_rdata == note_q) begin
						found_d = 1'b1;
					end
					if (is_last_s1) begin
						if (found_q || mem_rdata == note_q) begin
							total_d = tot_m1;
							if (tot_m1 == '0) begin
								none_d = 1'b1;
							end else if (!none_q && pos_ext >= tot_m1) begin
								pos_d = tot_m2[IDX_W-1:0];
							end
						end
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				if (mod_rsp.done) begin
					dc_d = mod_rsp.rem[3:0];
					if (mod_rsp.rem != '0) begin
						state_d = S_IDLE;
					end else if (cfg.mode == MODE_RANDOM) begin
						mod_req.start = 1'b1;
						mod_req.num   = rnd_q;
						mod_req.den   = MOD_DEN_W'(total_q);
						state_d       = S_RND;
					end else begin
						pos_d   = pick_pos[IDX_W-1:0];
						down_d  = pick_down;
						none_d  = 1'b0;
						state_d = S_RD;
					end
				end
			end
			S_RND: begin
				if (mod_rsp.done) begin
					pos_d   = pick_pos[IDX_W-1:0];
					none_d  = 1'b0;
					state_d = S_RD;
				end
			end
			S_RD: begin
				mem_re    = 1'b1;
				mem_raddr = pos_q;
				state_d   = S_NOTE;
			end
			S_NOTE: begin
				next_note_d = note_val;
				on_pend_d   = 1'b1;
				state_d     = snd_act_q ? S_OFF : S_ON;
			end
			S_OFF: begin
				if (slot_free) begin
					push.valid = 1'b1;
					push.ev    = EV_NOTE_OFF;
					push.note  = snd_note_q;
					push.last  = !on_pend_q;
					snd_act_d  = 1'b0;
					state_d    = on_pend_q ? S_ON : S_IDLE;
				end
			end
			S_ON: begin
				if (slot_free) begin
					push.valid = 1'b1;
					push.ev    = EV_NOTE_ON;
					push.note  = next_note_q;
					push.last  = 1'b1;
					snd_note_d = next_note_q;
					snd_act_d  = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= '0;
			pos_q      <= '0;
			none_q     <= 1'b1;
			down_q     <= 1'b0;
			dc_q       <= '0;
			snd_note_q <= '0;
			snd_act_q  <= 1'b0;
			found_q    <= 1'b0;
			on_pend_q  <= 1'b0;
			wk_q       <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			total_q    <= total_d;
			pos_q      <= pos_d;
			none_q     <= none_d;
			down_q     <= down_d;
			dc_q       <= dc_d;
			snd_note_q <= snd_note_d;
			snd_act_q  <= snd_act_d;
			found_q    <= found_d;
			on_pend_q  <= on_pend_d;
			wk_q       <= wk_d;
			rd_vld_s1  <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			note_q <= in_note;
			step_q <= in_step;
			rnd_q  <= in_rnd;
		end
		next_note_q <= next_note_d;
		rd_idx_s1   <= mem_raddr;
	end

endmodule

[src/arpeggiator_note_engine_unit.sv]
// Channel   Signals                        Content
// s_axis    tvalid tready tdata[23:0]      command, note, step_number, random_value
// m_axis    tvalid tready tdata tuser tlast out_note, event_res, last
// cfg       cfg_wr_en cfg_index cfg_data   arp_mode, octave_span, step_division, latch
//
// Key down and key up walk the held list one entry a cycle, through a memory with
// registered reads. A step tick waits on the bit-serial remainder, and in random order
// on a second remainder as well.
// arst_n clears all control state; held-list entries are never read before written.
// Take input only while idle; a result held in the output register stalls the sequencer.
`include "arpeggiator_note_engine_unit_defines.svh"

module arpeggiator_note_engine_unit
	import arpne_pkg::*;
#(
	parameter int HELD_CAPACITY = DEF_HELD_CAPACITY
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // command, note, step_number, random_value
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_note
	output logic                   m_axis_tuser,  // event_res
	output logic                   m_axis_tlast,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(HELD_CAPACITY);

	cfg_t              cfg_q;
	logic              out_vld_q;
	event_t            out_ev_q;
	logic [NOTE_W-1:0] out_note_q;
	logic              out_last_q;

	logic              slot_free;
	out_push_t         push;
	mod_req_t          mod_req;
	mod_rsp_t          mod_rsp;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [NOTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [NOTE_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_UP;
			cfg_q.span  <= SPAN_W'(1);
			cfg_q.div   <= DIV_W'(1);
			cfg_q.latch <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ARP_MODE:      cfg_q.mode  <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_OCTAVE_SPAN:   cfg_q.span  <= cfg_data[SPAN_W-1:0];
				REG_STEP_DIVISION: cfg_q.div   <= cfg_data[DIV_W-1:0];
				REG_LATCH:         cfg_q.latch <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// output register: load on push, drop once transferred
	assign slot_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.valid) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_ev_q   <= push.ev;
			out_note_q <= push.note;
			out_last_q <= push.last;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_note_q);
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tlast  = out_last_q;

	arpne_ctrl #(
		.HELD_CAPACITY(HELD_CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tdata[2:0]),
		.in_note  (s_axis_tdata[9:3]),
		.in_step  (s_axis_tdata[13:10]),
		.in_rnd   (s_axis_tdata[21:14]),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mod_req  (mod_req),
		.mod_rsp  (mod_rsp),
		.slot_free(slot_free),
		.push     (push)
	);

	arpne_held_mem #(
		.HELD_CAPACITY(HELD_CAPACITY)
	) u_held_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	arpne_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mod_req),
		.rsp   (mod_rsp)
	);

	`ARPNE_ASSERT_NOW(a_push_free, push.valid, (!out_vld_q || m_axis_tready), "push over held result")
	`ARPNE_ASSERT_NOW(a_mem_apart, mem_we && mem_re, mem_waddr != mem_raddr, "rd and wr at one entry")
	`ARPNE_ASSERT_NOW(a_mid_off, push.valid && !push.last, push.ev == EV_NOTE_OFF, "on without last")
	`ARPNE_ASSERT_NXT(a_mod_pulse, mod_rsp.done, !mod_rsp.done, "remainder done held for two cycles")

endmodule

[dv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import arpne_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int HELD_CAP      = DEF_HELD_CAPACITY;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int NUM_PHASES    = 24;
	localparam int PHASE_ITEMS   = 24;

	typedef struct {
		event_t            ev;
		logic [NOTE_W-1:0] note;
		logic              is_last;
	} arp_event_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // command, note, step_number, random_value
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // out_note
	logic                   m_axis_tuser;       // event_res
	logic                   m_axis_tlast;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	arpeggiator_note_engine_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// arpeggiator shadow state
	logic [NOTE_W-1:0] held_notes [HELD_CAP];
	int                held_cnt = 0;
	int                play_pos = -1;
	bit                going_down = 1'b0;
	int                div_cnt = 0;
	logic [NOTE_W-1:0] sound_note = '0;
	bit                sound_on = 1'b0;

	mode_t             cfg_mode = MODE_UP;
	logic [SPAN_W-1:0] cfg_span = 3'd1;
	logic [DIV_W-1:0]  cfg_div = 5'd1;
	logic              cfg_latch = 1'b0;

	arp_event_t            expected_events [$];
	logic [IN_TDATA_W-1:0] item_fifo [$];
	logic [NOTE_W-1:0]     pressed_keys [$];

	int err_cnt = 0;
	int items_taken = 0;
	int results_seen = 0;
	int max_held = 0;
	int full_drops = 0;
	int cyc_cnt = 0;
	int src_idle_pct = 37;
	int snk_idle_pct = 37;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic void expect_event(event_t ev, logic [NOTE_W-1:0] n, logic is_last);
		arp_event_t e;
		e.ev = ev;
		e.note = n;
		e.is_last = is_last;
		expected_events.push_back(e);
	endfunction

	function automatic void release_sounding();
		if (sound_on) begin
			sound_on = 1'b0;
			expect_event(EV_NOTE_OFF, sound_note, 1'b1);
		end
	endfunction

	function automatic void add_held(logic [NOTE_W-1:0] key);
		int pos;
		for (int i = 0; i < held_cnt; i++)
			if (held_notes[i] == key)
				return;
		if (held_cnt >= HELD_CAP) begin
			full_drops++;
			return;
		end
		pos = held_cnt;
		while (pos > 0 && held_notes[pos-1] > key) begin
			held_notes[pos] = held_notes[pos-1];
			pos--;
		end
		held_notes[pos] = key;
		held_cnt++;
		if (held_cnt > max_held)
			max_held = held_cnt;
	endfunction

	function automatic void remove_held(logic [NOTE_W-1:0] key);
		if (cfg_latch)
			return;
		for (int i = 0; i < held_cnt; i++) begin
			if (held_notes[i] == key) begin
				for (int j = i; j + 1 < held_cnt; j++)
					held_notes[j] = held_notes[j+1];
				held_cnt--;
				if (held_cnt == 0)
					play_pos = -1;
				else if (play_pos >= held_cnt)
					play_pos = held_cnt - 1;
				return;
			end
		end
	endfunction

	function automatic logic [NOTE_W-1:0] next_arp_note(logic [STEP_W-1:0] stepn,
			logic [RND_W-1:0] rnd);
		int span;
		int val;
		case (cfg_mode)
			MODE_DOWN: begin
				if (play_pos < 0)
					play_pos = held_cnt;
				play_pos--;
				if (play_pos < 0)
					play_pos = held_cnt - 1;
			end
			MODE_UPDOWN: begin
				if (play_pos < 0) begin
					play_pos = 0;
				end else begin
					play_pos += going_down ? -1 : 1;
					// turn at either end of the list
					if (play_pos >= held_cnt) begin
						play_pos = (held_cnt > 1) ? held_cnt - 2 : 0;
						going_down = 1'b1;
					end else if (play_pos < 0) begin
						play_pos = (held_cnt > 1) ? 1 : 0;
						going_down = 1'b0;
					end
				end
			end
			MODE_RANDOM: play_pos = int'(rnd) % held_cnt;
			default:     play_pos = (play_pos + 1) % held_cnt;
		endcase
		if (play_pos < 0 || play_pos >= held_cnt)
			play_pos = 0;
		span = (cfg_span > 3'd4) ? 4 : int'(cfg_span);
		val = int'(held_notes[play_pos]);
		if (span > 1)
			val += (int'(stepn) % span) * OCTAVE_STEP;
		return (val > int'(NOTE_MAX)) ? NOTE_MAX : NOTE_W'(val);
	endfunction

	function automatic void apply_item(logic [IN_TDATA_W-1:0] word);
		logic [CMD_W-1:0]  cmd = word[2:0];
		logic [NOTE_W-1:0] key = word[9:3];
		logic [STEP_W-1:0] stepn = word[13:10];
		logic [RND_W-1:0]  rnd = word[21:14];
		logic [NOTE_W-1:0] nxt;
		int                div;
		case (cmd)
			CMD_KEY_DOWN: add_held(key);
			CMD_KEY_UP:   remove_held(key);
			CMD_STEP: begin
				if (held_cnt == 0) begin
					release_sounding();
				end else begin
					div = (cfg_div == 0) ? 1 : ((cfg_div > 5'd16) ? 16 : int'(cfg_div));
					div_cnt = (div_cnt + 1) % div;
					if (div_cnt == 0) begin
						nxt = next_arp_note(stepn, rnd);
						if (sound_on)
							expect_event(EV_NOTE_OFF, sound_note, 1'b0);
						sound_note = nxt;
						sound_on = 1'b1;
						expect_event(EV_NOTE_ON, nxt, 1'b1);
					end
				end
			end
			CMD_GATE_REL, CMD_STOP: release_sounding();
			CMD_CLEAR: begin
				held_cnt = 0;
				play_pos = -1;
				release_sounding();
			end
			CMD_START: div_cnt = 0;
			default: ;
		endcase
	endfunction

	function automatic void check_event();
		arp_event_t e;
		results_seen++;
		if (expected_events.size() == 0) begin
			$error("unexpected result: event_res %0d out_note %0d last %0d",
				m_axis_tuser, m_axis_tdata[NOTE_W-1:0], m_axis_tlast);
			err_cnt++;
			return;
		end
		e = expected_events.pop_front();
		if (m_axis_tuser !== e.ev) begin
			$error("event_res mismatch: expected %0d, got %0d", e.ev, m_axis_tuser);
			err_cnt++;
		end
		if (m_axis_tdata[NOTE_W-1:0] !== e.note) begin
			$error("out_note mismatch: expected %0d, got %0d", e.note,
				m_axis_tdata[NOTE_W-1:0]);
			err_cnt++;
		end
		if (m_axis_tlast !== e.is_last) begin
			$error("last mismatch: expected %0d, got %0d", e.is_last, m_axis_tlast);
			err_cnt++;
		end
	endfunction

	function automatic void push_item(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] key,
			logic [STEP_W-1:0] stepn, logic [RND_W-1:0] rnd);
		item_fifo.push_back({2'b00, rnd, stepn, key, cmd});
	endfunction

	function automatic void push_rand(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] key);
		push_item(cmd, key, STEP_W'($urandom_range(15)), RND_W'($urandom_range(255)));
	endfunction

	// press 1 to 6 keys (sometimes 18), then a mix biased towards step ticks
	task automatic gen_phase(int n);
		int                k;
		int                pick;
		int                idx;
		logic [NOTE_W-1:0] key;
		k = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 6);
		repeat (k) begin
			key = NOTE_W'($urandom_range(127));
			pressed_keys.push_back(key);
			push_rand(CMD_KEY_DOWN, key);
		end
		repeat (n - k) begin
			pick = $urandom_range(99);
			key = NOTE_W'($urandom_range(127));
			if (pick < 20) begin
				pressed_keys.push_back(key);
				push_rand(CMD_KEY_DOWN, key);
			end else if (pick < 32) begin
				if (pressed_keys.size() != 0 && $urandom_range(9) < 7) begin
					idx = $urandom_range(pressed_keys.size() - 1);
					key = pressed_keys[idx];
					pressed_keys.delete(idx);
				end
				push_rand(CMD_KEY_UP, key);
			end else if (pick < 80) begin
				push_rand(CMD_STEP, key);
			end else if (pick < 84) begin
				push_rand(CMD_GATE_REL, key);
			end else if (pick < 86) begin
				pressed_keys.delete();
				push_rand(CMD_CLEAR, key);
			end else if (pick < 91) begin
				push_rand(CMD_START, key);
			end else if (pick < 96) begin
				push_rand(CMD_STOP, key);
			end else begin
				push_rand(CMD_UNUSED, key);
			end
		end
	endtask

	// hold the sender until every result is in and the engine has settled
	task automatic wait_drained();
		while (item_fifo.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_ARP_MODE:      cfg_mode = mode_t'(val[MODE_W-1:0]);
			REG_OCTAVE_SPAN:   cfg_span = val[SPAN_W-1:0];
			REG_STEP_DIVISION: cfg_div = val[DIV_W-1:0];
			REG_LATCH:         cfg_latch = val[0];
		endcase
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_item(s_axis_tdata);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= item_fifo.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_event();
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cyc_cnt,
				expected_events.size());
			$display("** arpeggiator_note_engine_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int span_val;
		int div_val;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: up mode, no octaves, every tick plays
		push_item(CMD_STEP, 7'd0, 4'hF, 8'hFF);
		push_item(CMD_KEY_DOWN, 7'd127, 4'h0, 8'h00);
		push_item(CMD_KEY_DOWN, 7'd0, 4'h0, 8'h00);
		push_item(CMD_KEY_DOWN, 7'd64, 4'h0, 8'h00);
		push_item(CMD_KEY_DOWN, 7'd64, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'hF, 8'hFF);
		push_item(CMD_STEP, 7'd0, 4'h7, 8'h80);
		push_item(CMD_KEY_UP, 7'd5, 4'h0, 8'h00);
		push_item(CMD_KEY_UP, 7'd127, 4'h0, 8'h00);
		push_item(CMD_GATE_REL, 7'd0, 4'h0, 8'h00);
		push_item(CMD_GATE_REL, 7'd0, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'h3, 8'h55);
		push_item(CMD_STOP, 7'd0, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'hC, 8'hAA);
		push_item(CMD_UNUSED, 7'd127, 4'hF, 8'hFF);
		push_item(CMD_START, 7'd0, 4'h0, 8'h00);
		push_item(CMD_CLEAR, 7'd0, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'h0, 8'h00);
		push_item(CMD_STOP, 7'd0, 4'h0, 8'h00);
		push_item(CMD_KEY_DOWN, 7'd100, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'h1, 8'h01);
		push_item(CMD_KEY_UP, 7'd100, 4'h0, 8'h00);
		push_item(CMD_STEP, 7'd0, 4'h0, 8'h00);
		wait_drained();

		// back-pressure: stall the receiver while ticks keep arriving
		write_reg(REG_ARP_MODE, CFG_DATA_W'(MODE_RANDOM));
		write_reg(REG_STEP_DIVISION, 5'd1);
		repeat (4) push_rand(CMD_KEY_DOWN, NOTE_W'($urandom_range(127)));
		hold_reqs++;
		repeat (36) push_rand(CMD_STEP, NOTE_W'($urandom_range(127)));
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			src_idle_pct = (p == 11) ? 0 : 37;
			snk_idle_pct = (p == 11) ? 0 : 37;
			span_val = (p < 8) ? p : $urandom_range(7);
			case (p)
				0:       div_val = 0;
				1:       div_val = 1;
				2:       div_val = 16;
				3:       div_val = 17;
				4:       div_val = 31;
				default: div_val = ($urandom_range(9) < 7) ? $urandom_range(1, 4)
					: $urandom_range(31);
			endcase
			write_reg(REG_ARP_MODE, CFG_DATA_W'(p % 4));
			write_reg(REG_OCTAVE_SPAN, CFG_DATA_W'(span_val));
			write_reg(REG_STEP_DIVISION, CFG_DATA_W'(div_val));
			write_reg(REG_LATCH, CFG_DATA_W'(p % 3 == 2));
			gen_phase(PHASE_ITEMS);
			wait_drained();
		end

		$display("Covered %0d input transfers over all modes, spans and divisions;", items_taken);
		$display("%0d note events checked, held list peaked at %0d, %0d inserts dropped full.",
			results_seen, max_held, full_drops);
		if (err_cnt == 0) begin
			$display("** arpeggiator_note_engine_unit: PASSED **");
		end else begin
			$display("** arpeggiator_note_engine_unit: FAILED **");
		end
		$finish;
	end

endmodule

[arpeggiator_note_engine_unit.f]
+incdir+src
src/arpne_pkg.sv
src/arpne_held_mem.sv
src/arpne_mod.sv
src/arpne_ctrl.sv
src/arpeggiator_note_engine_unit.sv
dv/tb.sv
